@@ src/quadrature_phase_generator_macros.svh @@
// Assertion macros for the quadrature phase generator.
// Expects signals named clock and reset in the including module.
`ifndef QUADRATURE_PHASE_GENERATOR_MACROS_SVH
`define QUADRATURE_PHASE_GENERATOR_MACROS_SVH

// same-cycle implication
`define QPG_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qpg: check failed");

// next-cycle implication
`define QPG_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qpg: check failed");

`endif

@@ src/qpg_pkg.sv @@
// Shared constants and types for the quadrature phase generator.
// No dependencies; used by qpg_sine_pipe and the top level.
`default_nettype none

package qpg_pkg;

   localparam int DEF_PHASE_BITS = 16;
   localparam int DEF_OUT_BITS   = 16;
   localparam int CFG_BITS       = 16;
   localparam int COUNT_BITS     = 16;

   // fixed-point polynomial format: unsigned Q30, one guard bit for 1.0
   localparam int Q_BITS = 30;
   localparam int ZW     = Q_BITS + 1;
   localparam logic [ZW-1:0] Q_ONE = ZW'(1) << Q_BITS;

   // accept stage, square, four Horner steps, final product, round
   localparam int NUM_STAGES = 8;

   // state memory holds one entry
   localparam int STATE_DEPTH = 1;
   localparam int STATE_AW    = 1;

   typedef logic [ZW-1:0] coef_type;

   // Taylor coefficients of sin(pi/2 * z), highest order first
   localparam coef_type POLY_COEF [5] = '{
      coef_type'(172272),
      coef_type'(5026995),
      coef_type'(85569306),
      coef_type'(693598667),
      coef_type'(1686629713)
   };

   typedef enum logic [0:0] {
      CSR_START_PHASE = 1'b0,
      CSR_PHASE_STEP  = 1'b1
   } csr_reg_type;

endpackage

`default_nettype wire

@@ src/quadrature_phase_generator.sv @@
// Quadrature phase generator: phase accumulator with cosine and sine outputs.
// Depends on qpg_pkg, qpg_ram, qpg_sine_pipe and the assertion macro header.
//
// Usage:
//   req channel: one beat per tick; req_restart reloads the start phase and
//   zeroes the bounce count before the beat's result is formed. The first beat
//   after reset always behaves as a restart.
//   rsp channel: one beat per req beat, in order: bounce index, x = cos, y = sin.
//   csr port: index 0 is start_phase, index 1 is phase_step; write only while
//   idle. phase_step applies at the next advance, start_phase at next restart.
//   Pipeline: rsp_valid rises once the beat has passed all eight stages (one
//   accept stage, six multiplier stages, one rounding stage).
//   Throughput: one beat per cycle while not stalled. Phase and count live in a
//   one-entry state memory read every cycle; the last write-back is forwarded so
//   back-to-back beats see fresh state.
//   Reset: clears the CSRs, pipeline valids and the started flag. The state
//   memory is not cleared; the first beat never reads it.
//   Stall: when rsp_ready is low, bubbles collapse; req_ready falls only once
//   all eight stages hold a beat.
`default_nettype none

`include "quadrature_phase_generator_macros.svh"

module quadrature_phase_generator #(
   parameter int PHASE_BITS = qpg_pkg::DEF_PHASE_BITS,
   parameter int OUT_BITS   = qpg_pkg::DEF_OUT_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_restart,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [qpg_pkg::COUNT_BITS-1:0]    rsp_bounce_index,
   output logic signed [OUT_BITS-1:0]             rsp_x_pos,
   output logic signed [OUT_BITS-1:0]             rsp_y_pos,
   input  wire logic                              csr_wr_en,
   input  wire logic                              csr_index,
   input  wire logic [qpg_pkg::CFG_BITS-1:0]      csr_wr_data
);

   localparam int NS = qpg_pkg::NUM_STAGES;
   localparam int CW = qpg_pkg::COUNT_BITS;
   localparam int SW = PHASE_BITS + CW;
   localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

   logic [qpg_pkg::CFG_BITS-1:0] start_phase_ff, start_phase_in;
   logic [qpg_pkg::CFG_BITS-1:0] phase_step_ff, phase_step_in;
   logic                         started_ff, started_in;
   logic                         fwd_ff, fwd_in;
   logic [SW-1:0]                wb_ff, wb_in;
   logic [SW-1:0]                rd_data, cur_state;
   logic [PHASE_BITS-1:0]        cur_phase, phase_now, cos_phase;
   logic [CW-1:0]                cur_cnt, cnt_now;
   logic                         accept, take_start;

   logic [NS:1]   vld_ff, vld_in, vld_prev, load_en;
   logic [NS+1:1] rdy;
   logic [CW-1:0] cnt_ff [1:NS];

   // csr writes
   always_comb begin
      start_phase_in = start_phase_ff;
      phase_step_in  = phase_step_ff;
      if (csr_wr_en) begin
         unique case (qpg_pkg::csr_reg_type'(csr_index))
            qpg_pkg::CSR_START_PHASE: start_phase_in = csr_wr_data;
            qpg_pkg::CSR_PHASE_STEP:  phase_step_in  = csr_wr_data;
         endcase
      end
   end

   // pipeline handshake: a stage loads when it is empty or drains downstream
   always_comb begin
      rdy[NS+1] = rsp_ready;
      for (int i = NS; i >= 1; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   assign vld_prev = {vld_ff[NS-1:1], req_valid};
   assign load_en  = rdy[NS:1] & vld_prev;
   assign vld_in   = (rdy[NS:1] & vld_prev) | (~rdy[NS:1] & vld_ff);
   assign accept   = load_en[1];

   // read-modify-write of the state entry, forward the last write-back
   assign cur_state  = fwd_ff ? wb_ff : rd_data;
   assign cur_phase  = cur_state[SW-1:CW];
   assign cur_cnt    = cur_state[CW-1:0];
   assign take_start = req_restart || !started_ff;
   assign phase_now  = take_start ? PHASE_BITS'(start_phase_ff) : cur_phase;
   assign cnt_now    = take_start ? '0 : cur_cnt;
   assign cos_phase  = phase_now + QUARTER;
   assign wb_in      = {phase_now + PHASE_BITS'(phase_step_ff), cnt_now + CW'(1)};
   assign started_in = started_ff || accept;
   assign fwd_in     = accept;

   qpg_ram #(
      .WIDTH (SW),
      .DEPTH (qpg_pkg::STATE_DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (qpg_pkg::STATE_AW'(0)),
      .wr_data (wb_in),
      .rd_en   (1'b1),
      .rd_addr (qpg_pkg::STATE_AW'(0)),
      .rd_data (rd_data)
   );

   qpg_sine_pipe #(
      .PHASE_BITS (PHASE_BITS),
      .OUT_BITS   (OUT_BITS)
   ) u_cos_pipe (
      .clock   (clock),
      .load_en (load_en),
      .phase   (cos_phase),
      .sine    (rsp_x_pos)
   );

   qpg_sine_pipe #(
      .PHASE_BITS (PHASE_BITS),
      .OUT_BITS   (OUT_BITS)
   ) u_sin_pipe (
      .clock   (clock),
      .load_en (load_en),
      .phase   (phase_now),
      .sine    (rsp_y_pos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_phase_ff <= '0;
         phase_step_ff  <= '0;
         started_ff     <= 1'b0;
         fwd_ff         <= 1'b0;
         vld_ff         <= '0;
      end else begin
         start_phase_ff <= start_phase_in;
         phase_step_ff  <= phase_step_in;
         started_ff     <= started_in;
         fwd_ff         <= fwd_in;
         vld_ff         <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wb_ff     <= wb_in;
         cnt_ff[1] <= cnt_now;
      end
      for (int i = 2; i <= NS; i++) begin
         if (load_en[i]) begin
            cnt_ff[i] <= cnt_ff[i-1];
         end
      end
   end

   assign req_ready        = rdy[1];
   assign rsp_valid        = vld_ff[NS];
   assign rsp_bounce_index = cnt_ff[NS];

   `QPG_ASSERT_NEXT(a_restart_clears_count, accept && take_start, cnt_ff[1] == '0)
   `QPG_ASSERT_IMPL(a_count_advances, accept && !take_start && $past(accept), cnt_now == $past(cnt_now) + CW'(1))
   `QPG_ASSERT_IMPL(a_empty_until_started, !started_ff, vld_ff == '0)

endmodule

`default_nettype wire

@@ src/qpg_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module qpg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/qpg_sine_pipe.sv @@
// Pipelined fixed-point sine of a phase: quadrant fold, Q30 Taylor polynomial
// in Horner form, rounding and saturation. Depends on qpg_pkg.
`default_nettype none

module qpg_sine_pipe #(
   parameter int PHASE_BITS = qpg_pkg::DEF_PHASE_BITS,
   parameter int OUT_BITS   = qpg_pkg::DEF_OUT_BITS
) (
   input  wire logic                                clock,
   input  wire logic [qpg_pkg::NUM_STAGES:1]        load_en,
   input  wire logic [PHASE_BITS-1:0]               phase,
   output logic signed [OUT_BITS-1:0]               sine
);

   localparam int NS     = qpg_pkg::NUM_STAGES;
   localparam int ZW     = qpg_pkg::ZW;
   localparam int QB     = qpg_pkg::Q_BITS;
   localparam int ZSHIFT = 32 - PHASE_BITS;
   localparam int RSH    = QB - (OUT_BITS - 1);
   localparam logic [ZW:0] RND_HALF = (ZW + 1)'(1) << (RSH - 1);
   localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS - 1){1'b1}}};

   function automatic logic [ZW-1:0] mul_q30(input logic [ZW-1:0] a,
                                             input logic [ZW-1:0] b);
      logic [2*ZW-1:0] prod;
      prod = (2 * ZW)'(a) * (2 * ZW)'(b);
      return prod[ZW+QB-1:QB];
   endfunction

   logic [1:0]            quad;
   logic [PHASE_BITS-3:0] rem;
   logic [ZW-1:0]         z_raw;
   logic [ZW-1:0]         z_prep;

   logic [ZW-1:0] z_ff   [1:6];
   logic          neg_ff [1:7];
   logic [ZW-1:0] zsq_ff [2:5];
   logic [ZW-1:0] p_ff   [3:6];
   logic [ZW-1:0] p_in   [3:6];
   logic [ZW-1:0] zsq_in;
   logic [ZW-1:0] s_ff, s_in;

   logic [ZW:0]             rnd_sum;
   logic [ZW-RSH:0]         rnd;
   logic [OUT_BITS-1:0]     mag;
   logic [OUT_BITS-1:0]     sine_ff, sine_in;

   // fold the phase into a quarter-turn argument
   assign quad   = phase[PHASE_BITS-1 -: 2];
   assign rem    = phase[PHASE_BITS-3:0];
   assign z_raw  = ZW'(rem) << ZSHIFT;
   assign z_prep = quad[0] ? (qpg_pkg::Q_ONE - z_raw) : z_raw;

   assign zsq_in = mul_q30(z_ff[1], z_ff[1]);

   genvar k;
   generate
      for (k = 3; k <= 6; k++) begin : g_horner
         if (k == 3) begin : g_first
            assign p_in[k] = qpg_pkg::POLY_COEF[1]
                           - mul_q30(zsq_ff[k-1], qpg_pkg::POLY_COEF[0]);
         end else begin : g_next
            assign p_in[k] = qpg_pkg::POLY_COEF[k-2]
                           - mul_q30(zsq_ff[k-1], p_ff[k-1]);
         end
      end
   endgenerate

   assign s_in = mul_q30(z_ff[6], p_ff[6]);

   // round half up, saturate, apply quadrant sign
   assign rnd_sum = {1'b0, s_ff} + RND_HALF;
   assign rnd     = rnd_sum[ZW:RSH];
   assign mag     = (rnd > (ZW - RSH + 1)'(OUT_MAX)) ? OUT_MAX : rnd[OUT_BITS-1:0];
   assign sine_in = neg_ff[7] ? (~mag + OUT_BITS'(1)) : mag;

   always_ff @(posedge clock) begin
      if (load_en[1]) begin
         z_ff[1]   <= z_prep;
         neg_ff[1] <= quad[1];
      end
      if (load_en[2]) begin
         zsq_ff[2] <= zsq_in;
      end
      for (int i = 2; i <= 6; i++) begin
         if (load_en[i]) begin
            z_ff[i] <= z_ff[i-1];
         end
      end
      for (int i = 2; i <= 7; i++) begin
         if (load_en[i]) begin
            neg_ff[i] <= neg_ff[i-1];
         end
      end
      for (int i = 3; i <= 5; i++) begin
         if (load_en[i]) begin
            zsq_ff[i] <= zsq_ff[i-1];
         end
      end
      for (int i = 3; i <= 6; i++) begin
         if (load_en[i]) begin
            p_ff[i] <= p_in[i];
         end
      end
      if (load_en[7]) begin
         s_ff <= s_in;
      end
      if (load_en[NS]) begin
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

`default_nettype wire
